// File: sv/jstk_rgb_pkg.sv
`default_nettype none
package jstk_rgb_pkg;

	// input and register widths
	localparam int SAMPLE_W = 10;
	localparam int DUTY_W   = 7;
	localparam int ANGLE_W  = 9;

	// cordic datapath
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 5;
	localparam int XY_FRAC      = 20;
	localparam int Z_FRAC       = 16;
	localparam int XY_W         = 36;
	localparam int Z_W          = 27;

	// register indexes
	localparam logic [1:0] REG_CENTER_X    = 2'd0;
	localparam logic [1:0] REG_CENTER_Y    = 2'd1;
	localparam logic [1:0] REG_DEAD_ZONE   = 2'd2;
	localparam logic [1:0] REG_PRESS_LEVEL = 2'd3;

	// led peaks in degrees
	localparam int PEAK_RED   = 90;
	localparam int PEAK_BLUE  = 210;
	localparam int PEAK_GREEN = 330;

	localparam int DUTY_FULL = 100;

	// atan(2^-i) in degrees, 16 fractional bits
	function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			5'd0:    v = Z_W'(2949120);
			5'd1:    v = Z_W'(1740967);
			5'd2:    v = Z_W'(919879);
			5'd3:    v = Z_W'(466945);
			5'd4:    v = Z_W'(234379);
			5'd5:    v = Z_W'(117302);
			5'd6:    v = Z_W'(58666);
			5'd7:    v = Z_W'(29335);
			5'd8:    v = Z_W'(14668);
			5'd9:    v = Z_W'(7334);
			5'd10:   v = Z_W'(3667);
			5'd11:   v = Z_W'(1833);
			5'd12:   v = Z_W'(917);
			5'd13:   v = Z_W'(458);
			5'd14:   v = Z_W'(229);
			5'd15:   v = Z_W'(115);
			5'd16:   v = Z_W'(57);
			5'd17:   v = Z_W'(29);
			5'd18:   v = Z_W'(14);
			5'd19:   v = Z_W'(7);
			5'd20:   v = Z_W'(4);
			5'd21:   v = Z_W'(2);
			5'd22:   v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	// duty from angular distance to a peak; divide by 6 via reciprocal 43691 / 2^18
	function automatic logic [DUTY_W-1:0] led_duty(input logic signed [ANGLE_W-1:0] angle,
			input int peak);
		logic signed [10:0] d;
		logic [8:0]         dm;
		logic [6:0]         e;
		logic [9:0]         v;
		logic [25:0]        prod;
		logic [DUTY_W-1:0]  q;
		logic [DUTY_W-1:0]  res;
		d = 11'(angle) - 11'(peak);
		if (d < -11'sd360)
			d = d + 11'sd720;
		else if (d < 11'sd0)
			d = d + 11'sd360;
		dm = d[8:0];
		e = (dm <= 9'd120) ? dm[6:0] : 7'(9'd360 - dm);
		v = 10'(5 * e) + 10'd5;
		prod = 26'(v) * 26'd43691;
		q = prod[24:18];
		if (dm > 9'd120 && dm < 9'd240)
			res = '0;
		else
			res = DUTY_W'(DUTY_FULL) - q;
		return res;
	endfunction

endpackage
`default_nettype wire

// File: sv/joystick_angle_to_rgb_duty_core.sv
`default_nettype none
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  x_sample, y_sample, switch_sample
// out       output     out_valid / out_stall red/green/blue_duty, angle_deg, leds_off
// cfg       input      cfg_we               cfg_index, cfg_data
//
// a word is rotated by the single shared add/shift cordic stage, one micro-rotation per
// cycle; words on an axis skip the rotations and go straight to the output load
// in_stall is high from acceptance until the result is loaded into the output register
// a loaded result waits under out_stall while the next word is already accepted
// arst_n clears the sequencer, the off flag and out_valid, and sets the cfg registers to their defaults
module joystick_angle_to_rgb_duty_core
	import jstk_rgb_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [SAMPLE_W-1:0]       x_sample,
	input  wire logic [SAMPLE_W-1:0]       y_sample,
	input  wire logic [SAMPLE_W-1:0]       switch_sample,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [DUTY_W-1:0]              red_duty,
	output logic [DUTY_W-1:0]              green_duty,
	output logic [DUTY_W-1:0]              blue_duty,
	output logic signed [ANGLE_W-1:0]      angle_deg,
	output logic                           leds_off,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [SAMPLE_W-1:0]       cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ITER  = 2'd1;
	localparam logic [1:0] ST_ANGLE = 2'd2;
	localparam logic [1:0] ST_LOAD  = 2'd3;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
	localparam int WHOLE_W = Z_W - Z_FRAC;

	logic [1:0] state_q;
	logic [STEP_W-1:0] step_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic signed [ANGLE_W-1:0] angle_q;
	logic centred_q;
	logic off_flag_q;
	logic [SAMPLE_W-1:0] center_x_q, center_y_q, dead_zone_q, press_level_q;

	logic out_valid_q;
	logic [DUTY_W-1:0] red_q, green_q, blue_q;
	logic signed [ANGLE_W-1:0] angle_out_q;
	logic leds_off_q;

	logic accept;
	logic load;

	// offsets and start vector
	logic signed [SAMPLE_W:0] dx, dy;
	logic [SAMPLE_W-1:0] adx, ady;
	logic signed [XY_W-1:0] dx_ext, dy_ext;
	logic signed [XY_W-1:0] x_init, y_init;
	logic signed [Z_W-1:0]  z_init;
	logic axis_case;
	logic signed [ANGLE_W-1:0] axis_angle;

	assign dx = $signed({1'b0, x_sample}) - $signed({1'b0, center_x_q});
	assign dy = $signed({1'b0, y_sample}) - $signed({1'b0, center_y_q});
	assign adx = dx[SAMPLE_W] ? SAMPLE_W'(-dx) : dx[SAMPLE_W-1:0];
	assign ady = dy[SAMPLE_W] ? SAMPLE_W'(-dy) : dy[SAMPLE_W-1:0];
	assign dx_ext = XY_W'(dx) <<< XY_FRAC;
	assign dy_ext = XY_W'(dy) <<< XY_FRAC;

	always_comb begin
		if (dx[SAMPLE_W]) begin
			// left half plane: rotate by half a turn first
			x_init = -dx_ext;
			y_init = dy_ext;
			z_init = dy[SAMPLE_W] ? Z_W'(180 * (1 << Z_FRAC)) : Z_W'(-180 * (1 << Z_FRAC));
		end else begin
			x_init = dx_ext;
			y_init = -dy_ext;
			z_init = '0;
		end
	end

	// words on an axis skip the rotations
	always_comb begin
		axis_case = 1'b0;
		axis_angle = '0;
		if (dy == '0) begin
			axis_case = 1'b1;
			axis_angle = dx[SAMPLE_W] ? -ANGLE_W'(180) : '0;
		end else if (dx == '0) begin
			axis_case = 1'b1;
			axis_angle = dy[SAMPLE_W] ? ANGLE_W'(90) : -ANGLE_W'(90);
		end
	end

	// shared micro-rotation unit
	logic signed [XY_W-1:0] sh_x, sh_y, x_next, y_next;
	logic signed [Z_W-1:0]  z_next;
	logic signed [Z_W-1:0]  tab;

	assign sh_x = x_q >>> step_q;
	assign sh_y = y_q >>> step_q;
	assign tab  = atan_entry(step_q);

	always_comb begin
		if (!y_q[XY_W-1]) begin
			x_next = x_q + sh_y;
			y_next = y_q - sh_x;
			z_next = z_q + tab;
		end else begin
			x_next = x_q - sh_y;
			y_next = y_q + sh_x;
			z_next = z_q - tab;
		end
	end

	// whole degrees, truncated toward zero and clamped
	logic [Z_W-1:0] z_mag;
	logic [WHOLE_W-1:0] whole;
	logic [WHOLE_W-1:0] whole_cl;
	logic signed [ANGLE_W-1:0] angle_fin;

	assign z_mag = z_q[Z_W-1] ? Z_W'(-z_q) : Z_W'(z_q);
	assign whole = z_mag[Z_W-1:Z_FRAC];
	assign whole_cl = (whole > WHOLE_W'(180)) ? WHOLE_W'(180) : whole;
	assign angle_fin = z_q[Z_W-1] ? -ANGLE_W'(whole_cl) : ANGLE_W'(whole_cl);

	// handshake
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign load = (state_q == ST_LOAD) && (!out_valid_q || !out_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			off_flag_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						if (switch_sample < press_level_q)
							off_flag_q <= !off_flag_q;
						state_q <= axis_case ? ST_LOAD : ST_ITER;
					end
				end
				ST_ITER: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST)
						state_q <= ST_ANGLE;
				end
				ST_ANGLE: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// cordic datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
			centred_q <= (adx < dead_zone_q) && (ady < dead_zone_q);
			if (axis_case)
				angle_q <= axis_angle;
		end else if (state_q == ST_ITER) begin
			x_q <= x_next;
			y_q <= y_next;
			z_q <= z_next;
		end else if (state_q == ST_ANGLE) begin
			angle_q <= angle_fin;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= SAMPLE_W'(512);
			center_y_q <= SAMPLE_W'(512);
			dead_zone_q <= SAMPLE_W'(10);
			press_level_q <= SAMPLE_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:    center_x_q <= cfg_data;
				REG_CENTER_Y:    center_y_q <= cfg_data;
				REG_DEAD_ZONE:   dead_zone_q <= cfg_data;
				REG_PRESS_LEVEL: press_level_q <= cfg_data;
				default:         center_x_q <= center_x_q;
			endcase
		end
	end

	// duty selection
	logic [DUTY_W-1:0] red_d, green_d, blue_d;

	always_comb begin
		if (off_flag_q) begin
			red_d = '0;
			green_d = '0;
			blue_d = '0;
		end else if (centred_q) begin
			red_d = DUTY_W'(DUTY_FULL);
			green_d = DUTY_W'(DUTY_FULL);
			blue_d = DUTY_W'(DUTY_FULL);
		end else begin
			red_d = led_duty(angle_q, PEAK_RED);
			green_d = led_duty(angle_q, PEAK_GREEN);
			blue_d = led_duty(angle_q, PEAK_BLUE);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_q <= red_d;
			green_q <= green_d;
			blue_q <= blue_d;
			angle_out_q <= angle_q;
			leds_off_q <= off_flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign red_duty = red_q;
	assign green_duty = green_q;
	assign blue_duty = blue_q;
	assign angle_deg = angle_out_q;
	assign leds_off = leds_off_q;

endmodule
`default_nettype wire

// File: tb/sv/joystick_angle_to_rgb_duty_core_test.sv
`timescale 1ns / 100ps
module joystick_angle_to_rgb_duty_core_test;
	import jstk_rgb_pkg::*;

	// one joystick sample or one register write, in driving order
	typedef struct {
		logic                is_cfg;
		logic [1:0]          idx;
		logic [SAMPLE_W-1:0] data;
		logic [SAMPLE_W-1:0] xs;
		logic [SAMPLE_W-1:0] ys;
		logic [SAMPLE_W-1:0] sw;
	} sample_t;

	// one predicted duty word
	typedef struct {
		logic [DUTY_W-1:0]  red;
		logic [DUTY_W-1:0]  green;
		logic [DUTY_W-1:0]  blue;
		logic [ANGLE_W-1:0] angle;
		logic               off;
	} duty_word_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_JITTER, STALL_CHOKE} stall_mode_t;

	// atan(2^-i) in degrees with 16 fractional bits
	localparam longint ATAN_DEG [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117302, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] x_sample = '0;
	logic [SAMPLE_W-1:0] y_sample = '0;
	logic [SAMPLE_W-1:0] switch_sample = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DUTY_W-1:0]   red_duty;
	logic [DUTY_W-1:0]   green_duty;
	logic [DUTY_W-1:0]   blue_duty;
	logic signed [ANGLE_W-1:0] angle_deg;
	logic                leds_off;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = '0;
	logic [SAMPLE_W-1:0] cfg_data = '0;

	sample_t    sample_q[$];
	duty_word_t duty_q[$];

	// predictor copy of registers and the off flag
	int   reg_cx, reg_cy, reg_dz, reg_press;
	logic lit_off;

	// register values as planned while the stimulus is built
	int plan_cx = 512, plan_cy = 512, plan_dz = 10, plan_press = 10;

	logic        in_fire = 1'b0;
	int          gap_left = 0;
	int          burst_left = 8;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	int mismatches = 0;
	int n_samples = 0, n_words = 0, n_writes = 0;
	int n_centred = 0, n_dark = 0, n_lit = 0;

	joystick_angle_to_rgb_duty_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_sample(x_sample),
		.y_sample(y_sample),
		.switch_sample(switch_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_duty(red_duty),
		.green_duty(green_duty),
		.blue_duty(blue_duty),
		.angle_deg(angle_deg),
		.leds_off(leds_off),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// vectoring cordic on the offsets, angle of (dx, -dy) in whole degrees
	function automatic int stick_angle_deg(int dx, int dy);
		longint vx, vy, vz, nx;
		int     i;
		if (dy == 0)
			return (dx < 0) ? -180 : 0;
		if (dx == 0)
			return (dy < 0) ? 90 : -90;
		vx = longint'(dx) * (longint'(1) << XY_FRAC);
		vy = -longint'(dy) * (longint'(1) << XY_FRAC);
		vz = 0;
		// left half plane: fold over and start from the far side
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			vz = longint'((dy < 0) ? 180 : -180) * (longint'(1) << Z_FRAC);
		end
		for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (vy >= 0) begin
				nx = vx + (vy >>> i);
				vy = vy - (vx >>> i);
				vz = vz + ATAN_DEG[i];
			end else begin
				nx = vx - (vy >>> i);
				vy = vy + (vx >>> i);
				vz = vz - ATAN_DEG[i];
			end
			vx = nx;
		end
		// truncate toward zero, then clamp
		if (vz < 0)
			vz = -((-vz) >>> Z_FRAC);
		else
			vz = vz >>> Z_FRAC;
		if (vz > 180)
			vz = 180;
		if (vz < -180)
			vz = -180;
		return int'(vz);
	endfunction

	// duty falls off linearly with distance from the peak
	function automatic logic [DUTY_W-1:0] duty_toward(int angle, int peak);
		int d, e;
		d = angle - peak;
		while (d < 0)
			d += 360;
		while (d >= 360)
			d -= 360;
		if (d > 120 && d < 240)
			return '0;
		e = (d <= 120) ? d : 360 - d;
		return DUTY_W'(DUTY_FULL - (5 * e + 5) / 6);
	endfunction

	// next duty word for one accepted sample, updates the off flag
	task automatic predict_duties(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
			input logic [SAMPLE_W-1:0] sw, output duty_word_t w);
		int dx, dy, ang;
		dx = int'(xs) - reg_cx;
		dy = int'(ys) - reg_cy;
		ang = stick_angle_deg(dx, dy);
		if (int'(sw) < reg_press)
			lit_off = !lit_off;
		w.angle = ANGLE_W'(ang);
		w.off = lit_off;
		if (lit_off) begin
			w.red = '0;
			w.green = '0;
			w.blue = '0;
			n_dark++;
		end else if ((dx < 0 ? -dx : dx) < reg_dz && (dy < 0 ? -dy : dy) < reg_dz) begin
			w.red = DUTY_W'(DUTY_FULL);
			w.green = DUTY_W'(DUTY_FULL);
			w.blue = DUTY_W'(DUTY_FULL);
			n_centred++;
		end else begin
			w.red = duty_toward(ang, PEAK_RED);
			w.green = duty_toward(ang, PEAK_GREEN);
			w.blue = duty_toward(ang, PEAK_BLUE);
			n_lit++;
		end
	endtask

	task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t %s: expected %0d, got %0d", $time, name, $signed(want),
					$signed(got));
		end
	endtask

	// stimulus building
	task automatic add_sample(input int xs, input int ys, input int sw);
		sample_t s;
		s.is_cfg = 1'b0;
		s.idx = REG_CENTER_X;
		s.data = '0;
		s.xs = SAMPLE_W'(xs);
		s.ys = SAMPLE_W'(ys);
		s.sw = SAMPLE_W'(sw);
		sample_q.push_back(s);
	endtask

	task automatic add_cfg(input logic [1:0] idx, input int val);
		sample_t s;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.data = SAMPLE_W'(val);
		s.xs = '0;
		s.ys = '0;
		s.sw = '0;
		sample_q.push_back(s);
		case (idx)
			REG_CENTER_X:  plan_cx = val;
			REG_CENTER_Y:  plan_cy = val;
			REG_DEAD_ZONE: plan_dz = val;
			default:       plan_press = val;
		endcase
	endtask

	function automatic int near(int c, int r);
		int v;
		v = c + int'($urandom_range(0, 2 * r)) - r;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v;
	endfunction

	// random samples biased toward the dead zone, the axes and rare presses
	task automatic add_random(input int count);
		int n, sel, xs, ys, sw;
		for (n = 0; n < count; n++) begin
			sel = $urandom_range(0, 9);
			xs = $urandom_range(0, 1023);
			ys = $urandom_range(0, 1023);
			if (sel < 3) begin
				xs = near(plan_cx, plan_dz + 2);
				ys = near(plan_cy, plan_dz + 2);
			end else if (sel == 3) begin
				xs = plan_cx;
			end else if (sel == 4) begin
				ys = plan_cy;
			end
			sw = $urandom_range(0, 1023);
			if ($urandom_range(0, 15) != 0)
				sw = $urandom_range(plan_press, 1023);
			add_sample(xs, ys, sw);
		end
	endtask

	// sender: bursts of words with random gaps, register writes only when idle
	always @(negedge clk) begin
		sample_t s;
		logic    we_next;
		we_next = 1'b0;
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (sample_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (sample_q[0].is_cfg) begin
				in_valid <= 1'b0;
				if (!in_valid && duty_q.size() == 0 && !cfg_we) begin
					s = sample_q.pop_front();
					we_next = 1'b1;
					cfg_index <= s.idx;
					cfg_data <= s.data;
				end
			end else begin
				s = sample_q.pop_front();
				in_valid <= 1'b1;
				x_sample <= s.xs;
				y_sample <= s.ys;
				switch_sample <= s.sw;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
		cfg_we <= we_next;
	end

	// receiver: stall pattern switching between free flow, jitter and long chokes
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_left <= $urandom_range(16, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_JITTER: out_stall <= ($urandom_range(0, 2) == 0);
			default:      out_stall <= ($urandom_range(0, 5) != 0);
		endcase
	end

	// monitor: track registers, predict on accepted samples, check duty words
	always @(posedge clk) begin
		duty_word_t w;
		if (!arst_n) begin
			reg_cx = 512;
			reg_cy = 512;
			reg_dz = 10;
			reg_press = 10;
			lit_off = 1'b0;
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (cfg_we) begin
				n_writes++;
				case (cfg_index)
					REG_CENTER_X:  reg_cx = int'(cfg_data);
					REG_CENTER_Y:  reg_cy = int'(cfg_data);
					REG_DEAD_ZONE: reg_dz = int'(cfg_data);
					default:       reg_press = int'(cfg_data);
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_duties(x_sample, y_sample, switch_sample, w);
				duty_q.push_back(w);
				n_samples++;
			end
			if (out_valid && !out_stall) begin
				if (duty_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t duty word with none expected", $time);
				end else begin
					w = duty_q.pop_front();
					n_words++;
					check_field("red_duty", w.red, red_duty);
					check_field("green_duty", w.green, green_duty);
					check_field("blue_duty", w.blue, blue_duty);
					check_field("angle_deg", w.angle, angle_deg);
					check_field("leds_off", w.off, leds_off);
				end
			end
		end
	end

	// main sequence
	initial begin
		int ph, cx, cy, dz, pl;
		// directed words at reset settings
		add_sample(512, 512, 1023);
		add_sample(1023, 512, 1023);
		add_sample(0, 512, 1023);
		add_sample(512, 0, 1023);
		add_sample(512, 1023, 1023);
		add_sample(0, 0, 1023);
		add_sample(0, 1023, 1023);
		add_sample(1023, 0, 1023);
		add_sample(1023, 1023, 1023);
		add_sample(521, 512, 1023);
		add_sample(522, 512, 1023);
		add_sample(512, 502, 1023);
		add_sample(513, 511, 500);
		add_sample(300, 700, 0);
		add_sample(700, 300, 512);
		add_sample(300, 300, 9);
		add_sample(700, 700, 10);
		add_sample(511, 900, 1023);
		add_sample(100, 513, 682);
		add_sample(900, 511, 341);
		// register extremes first, then random settings
		for (ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin cx = 0; cy = 0; dz = 0; pl = 0; end
				1: begin cx = 1023; cy = 1023; dz = 1023; pl = 1023; end
				2: begin cx = 512; cy = 512; dz = 10; pl = 10; end
				3: begin cx = 0; cy = 1023; dz = 1; pl = 1; end
				default: begin
					cx = $urandom_range(0, 1023);
					cy = $urandom_range(0, 1023);
					dz = $urandom_range(0, 40);
					pl = $urandom_range(0, 60);
				end
			endcase
			add_cfg(REG_CENTER_X, cx);
			add_cfg(REG_CENTER_Y, cy);
			add_cfg(REG_DEAD_ZONE, dz);
			add_cfg(REG_PRESS_LEVEL, pl);
			add_random((ph == 1) ? 80 : 215);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (sample_q.size() != 0 || in_valid || cfg_we || duty_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d samples over %0d register writes gave %0d duty words", n_samples,
			n_writes, n_words);
		$display("predicted %0d centred, %0d switched off, %0d steered by angle",
			n_centred, n_dark, n_lit);
		if (mismatches == 0 && duty_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#12000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
